// File: hw/rtl/regime_shift_detector_defines.svh
// ----------------------------------------------------------------------------
// Regime shift detector assertion macros
// Concurrent assertion wrappers shared by the detector modules.
// ----------------------------------------------------------------------------
`ifndef REGIME_SHIFT_DETECTOR_DEFINES_SVH
`define REGIME_SHIFT_DETECTOR_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Checked on every rising clock edge outside reset.
`define RSD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// Checked on every rising clock edge, reset included.
`define RSD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define RSD_ASSERT(label, prop, msg)
`define RSD_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// File: hw/rtl/rsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Regime shift detector package
// Shared widths, register indexes, configuration bundle and sequencer states.
// ----------------------------------------------------------------------------
package rsd_pkg;

    localparam int DATA_W         = 64;
    localparam int WIN_W          = 16;
    localparam int RUN_W          = 16;
    localparam int WARMUP_SAMPLES = 16;
    localparam int SEEN_W         = $clog2(WARMUP_SAMPLES + 1);

    // Divider retires this many quotient bits per cycle.
    localparam int DIV_STEP_BITS  = 2;
    localparam int DIV_STEPS      = DATA_W / DIV_STEP_BITS;
    localparam int DIV_CNT_W      = $clog2(DIV_STEPS);

    localparam int APB_ADDR_W     = 6;
    localparam int APB_DATA_W     = 64;
    localparam int OUT_TDATA_W    = 136;

    typedef enum logic [2:0] {
        REG_SLOW_WINDOW     = 3'd0,
        REG_FAST_WINDOW     = 3'd1,
        REG_ESCALATE_THRESH = 3'd2,
        REG_STABLE_THRESH   = 3'd3,
        REG_REGION_BOUND    = 3'd4,
        REG_REGION_MINIMUM  = 3'd5,
        REG_REGION_MAXIMUM  = 3'd6,
        REG_RETURN_COUNT    = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [WIN_W-1:0]         slow_window;
        logic [WIN_W-1:0]         fast_window;
        logic [DATA_W-1:0]        escalate_threshold;
        logic [DATA_W-1:0]        stable_threshold;
        logic                     region_bound;
        logic signed [DATA_W-1:0] region_minimum;
        logic signed [DATA_W-1:0] region_maximum;
        logic [RUN_W-1:0]         return_count_needed;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SLOW_DIV,
        ST_FAST_DIV,
        ST_MEASURE,
        ST_DECIDE,
        ST_EMIT
    } seq_state_t;

endpackage

// File: hw/rtl/rsd_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Regime shift detector configuration registers
// APB register file holding windows, thresholds and the range settings.
// ----------------------------------------------------------------------------
module rsd_regs
    import rsd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t     cfg_reg;
    reg_idx_t reg_idx;
    logic     wr_en;

    // Registers sit on 8-byte boundaries.
    assign reg_idx = reg_idx_t'(paddr[APB_ADDR_W-1:3]);
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.slow_window         <= WIN_W'(64);
            cfg_reg.fast_window         <= WIN_W'(8);
            cfg_reg.escalate_threshold  <= DATA_W'(1000);
            cfg_reg.stable_threshold    <= DATA_W'(500);
            cfg_reg.region_bound        <= 1'b0;
            cfg_reg.region_minimum      <= '0;
            cfg_reg.region_maximum      <= '0;
            cfg_reg.return_count_needed <= RUN_W'(4);
        end else if (wr_en) begin
            case (reg_idx)
                REG_SLOW_WINDOW:     cfg_reg.slow_window         <= pwdata[WIN_W-1:0];
                REG_FAST_WINDOW:     cfg_reg.fast_window         <= pwdata[WIN_W-1:0];
                REG_ESCALATE_THRESH: cfg_reg.escalate_threshold  <= pwdata[DATA_W-1:0];
                REG_STABLE_THRESH:   cfg_reg.stable_threshold    <= pwdata[DATA_W-1:0];
                REG_REGION_BOUND:    cfg_reg.region_bound        <= pwdata[0];
                REG_REGION_MINIMUM:  cfg_reg.region_minimum      <= pwdata[DATA_W-1:0];
                REG_REGION_MAXIMUM:  cfg_reg.region_maximum      <= pwdata[DATA_W-1:0];
                REG_RETURN_COUNT:    cfg_reg.return_count_needed <= pwdata[RUN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_SLOW_WINDOW:     prdata = APB_DATA_W'(cfg_reg.slow_window);
            REG_FAST_WINDOW:     prdata = APB_DATA_W'(cfg_reg.fast_window);
            REG_ESCALATE_THRESH: prdata = APB_DATA_W'(cfg_reg.escalate_threshold);
            REG_STABLE_THRESH:   prdata = APB_DATA_W'(cfg_reg.stable_threshold);
            REG_REGION_BOUND:    prdata = APB_DATA_W'(cfg_reg.region_bound);
            REG_REGION_MINIMUM:  prdata = APB_DATA_W'(cfg_reg.region_minimum);
            REG_REGION_MAXIMUM:  prdata = APB_DATA_W'(cfg_reg.region_maximum);
            REG_RETURN_COUNT:    prdata = APB_DATA_W'(cfg_reg.return_count_needed);
            default:             prdata = '0;
        endcase
    end

endmodule

// File: hw/rtl/rsd_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Regime shift detector divider
// Iterative restoring divider: 64-bit dividend by 16-bit window, two bits per
// cycle, shared by both running averages.
// ----------------------------------------------------------------------------
`include "regime_shift_detector_defines.svh"

module rsd_div
    import rsd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [DATA_W-1:0] dividend,
    input  logic [WIN_W-1:0]  divisor,
    output logic              done,
    output logic [DATA_W-1:0] quotient
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DATA_W-1:0]    dvd_reg;
    logic [DATA_W-1:0]    quot_reg;
    logic [WIN_W-1:0]     rem_reg;
    logic [WIN_W-1:0]     dsr_reg;

    logic [DATA_W-1:0]    dvd_next;
    logic [DATA_W-1:0]    quot_next;
    logic [WIN_W-1:0]     rem_next;

    always_comb begin : step_logic
        logic [WIN_W:0]    trial;
        logic [WIN_W-1:0]  r;
        logic [DATA_W-1:0] d;
        logic [DATA_W-1:0] q;
        r = rem_reg;
        d = dvd_reg;
        q = quot_reg;
        trial = '0;
        for (int i = 0; i < DIV_STEP_BITS; i++) begin
            trial = {r, d[DATA_W-1]};
            d     = {d[DATA_W-2:0], 1'b0};
            if (trial >= {1'b0, dsr_reg}) begin
                r = WIN_W'(trial - {1'b0, dsr_reg});
                q = {q[DATA_W-2:0], 1'b1};
            end else begin
                r = trial[WIN_W-1:0];
                q = {q[DATA_W-2:0], 1'b0};
            end
        end
        rem_next  = r;
        dvd_next  = d;
        quot_next = q;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg  <= dividend;
            quot_reg <= '0;
            rem_reg  <= '0;
            // A window of zero behaves as a window of one.
            dsr_reg  <= (divisor == '0) ? WIN_W'(1) : divisor;
        end else if (busy_reg) begin
            dvd_reg  <= dvd_next;
            quot_reg <= quot_next;
            rem_reg  <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

    `RSD_ASSERT(a_div_no_restart, start |-> !busy_reg, "divider started while busy")
    `RSD_ASSERT(a_div_done_idle, done_reg |-> !busy_reg, "divider done while still busy")
    `RSD_ASSERT(a_div_start_busy, start |=> busy_reg, "divider did not begin after start")

endmodule

// File: hw/rtl/regime_shift_detector.sv
`timescale 1ns / 1ps
// A sample after the first takes two divider passes of 32 two-bit steps, slow average first,
// then the measure, decide and emit states before the result word. A clear word or the
// first sample after reset or clear needs no division and goes straight to measure.
// One word at a time: s_tready rises with the result word; emit waits while m_tready stalls.
// Reset (aresetn low, synchronous) clears the sequencer, averages and regime state (not the
// payload registers) and restores register defaults.
// ----------------------------------------------------------------------------
// Regime shift detector
// Dual running-average crossover detector with hysteresis and range events.
// ----------------------------------------------------------------------------
`include "regime_shift_detector_defines.svh"

module regime_shift_detector
    import rsd_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    // APB configuration port
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready,
    // Sample stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [DATA_W-1:0]      s_tdata,   // [63:0] sample
    input  logic                   s_tuser,   // [0] mode (1 clears all state)
    // Result stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [0] escalated, [1] warmup_active, [2] event_raised, [3] event_held,
    // [67:4] slow_average, [131:68] fast_average, [135:132] zero
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    cfg_t cfg;

    seq_state_t        state_reg, state_next;
    logic              mode_reg;
    logic [DATA_W-1:0] sample_reg;
    logic [DATA_W-1:0] slow_avg_reg;
    logic [DATA_W-1:0] fast_avg_reg;
    logic [SEEN_W-1:0] seen_reg;
    logic              esc_reg;
    logic [RUN_W-1:0]  run_reg;
    logic              event_reg;
    logic              raised_reg;
    logic              lt_reg;
    logic [DATA_W-1:0] diverge_reg;
    logic              m_tvalid_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;

    logic              in_accept;
    logic              div_start;
    logic [DATA_W-1:0] div_dividend;
    logic [WIN_W-1:0]  div_divisor;
    logic              div_lt;
    logic              div_done;
    logic [DATA_W-1:0] div_quot;
    logic              out_load;
    logic [DATA_W-1:0] approach_avg;

    function automatic logic s_less(input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] b);
        return $signed(a) < $signed(b);
    endfunction

    function automatic logic [DATA_W-1:0] gap(input logic [DATA_W-1:0] a,
                                              input logic [DATA_W-1:0] b);
        return s_less(a, b) ? (b - a) : (a - b);
    endfunction

    rsd_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rsd_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign in_accept = s_tvalid && s_tready;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    if (s_tuser || seen_reg == '0) begin
                        state_next = ST_MEASURE;
                    end else begin
                        state_next = ST_SLOW_DIV;
                    end
                end
            end
            ST_SLOW_DIV: begin
                if (div_done) begin
                    state_next = ST_FAST_DIV;
                end
            end
            ST_FAST_DIV: begin
                if (div_done) begin
                    state_next = ST_MEASURE;
                end
            end
            ST_MEASURE: state_next = ST_DECIDE;
            ST_DECIDE:  state_next = ST_EMIT;
            ST_EMIT: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs: handshake and divider launch.
    always_comb begin
        s_tready     = 1'b0;
        div_start    = 1'b0;
        div_dividend = gap(sample_reg, fast_avg_reg);
        div_divisor  = cfg.fast_window;
        div_lt       = s_less(sample_reg, fast_avg_reg);
        out_load     = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready     = 1'b1;
                div_start    = s_tvalid && !s_tuser && (seen_reg != '0);
                div_dividend = gap(s_tdata, slow_avg_reg);
                div_divisor  = cfg.slow_window;
                div_lt       = s_less(s_tdata, slow_avg_reg);
            end
            ST_SLOW_DIV: div_start = div_done;
            ST_EMIT:     out_load  = !m_tvalid_reg || m_tready;
            default: ;
        endcase
    end

    // Move the average by the quotient, toward the sample.
    always_comb begin
        if (state_reg == ST_SLOW_DIV) begin
            approach_avg = lt_reg ? slow_avg_reg - div_quot : slow_avg_reg + div_quot;
        end else begin
            approach_avg = lt_reg ? fast_avg_reg - div_quot : fast_avg_reg + div_quot;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            slow_avg_reg <= '0;
            fast_avg_reg <= '0;
            seen_reg     <= '0;
            esc_reg      <= 1'b0;
            run_reg      <= '0;
            event_reg    <= 1'b0;
            raised_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (in_accept && !s_tuser && seen_reg == '0) begin
                slow_avg_reg <= s_tdata;
                fast_avg_reg <= s_tdata;
            end
            if (state_reg == ST_SLOW_DIV && div_done) begin
                slow_avg_reg <= approach_avg;
            end
            if (state_reg == ST_FAST_DIV && div_done) begin
                fast_avg_reg <= approach_avg;
            end

            if (state_reg == ST_DECIDE) begin
                raised_reg <= 1'b0;
                if (mode_reg) begin
                    slow_avg_reg <= '0;
                    fast_avg_reg <= '0;
                    seen_reg     <= '0;
                    esc_reg      <= 1'b0;
                    run_reg      <= '0;
                    event_reg    <= 1'b0;
                end else begin
                    logic [SEEN_W-1:0] seen_new;
                    logic [RUN_W-1:0]  need;
                    logic [RUN_W:0]    run_inc;
                    seen_new = (seen_reg < SEEN_W'(WARMUP_SAMPLES)) ? seen_reg + 1'b1
                                                                     : seen_reg;
                    need     = (cfg.return_count_needed == '0) ? RUN_W'(1)
                                                               : cfg.return_count_needed;
                    run_inc  = {1'b0, run_reg} + 1'b1;
                    seen_reg <= seen_new;
                    if (seen_new >= SEEN_W'(WARMUP_SAMPLES)) begin
                        if (!cfg.region_bound) begin
                            if (!esc_reg && diverge_reg > cfg.escalate_threshold) begin
                                esc_reg <= 1'b1;
                            end else if (esc_reg && diverge_reg < cfg.stable_threshold) begin
                                esc_reg <= 1'b0;
                            end
                        end else if (s_less(sample_reg, cfg.region_minimum) ||
                                     s_less(cfg.region_maximum, sample_reg)) begin
                            run_reg <= '0;
                            if (!esc_reg) begin
                                esc_reg    <= 1'b1;
                                event_reg  <= 1'b1;
                                raised_reg <= 1'b1;
                            end
                        end else if (esc_reg) begin
                            if (run_inc >= {1'b0, need}) begin
                                esc_reg   <= 1'b0;
                                run_reg   <= '0;
                                event_reg <= 1'b0;
                            end else begin
                                run_reg <= run_inc[RUN_W-1:0];
                            end
                        end
                    end
                end
            end

            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            mode_reg   <= s_tuser;
            sample_reg <= s_tdata;
        end
        if (div_start) begin
            lt_reg <= div_lt;
        end
        if (state_reg == ST_MEASURE) begin
            diverge_reg <= gap(fast_avg_reg, slow_avg_reg);
        end
        if (out_load) begin
            m_tdata_reg <= {4'b0000, fast_avg_reg, slow_avg_reg, event_reg, raised_reg,
                            (seen_reg < SEEN_W'(WARMUP_SAMPLES)), esc_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `RSD_ASSERT(a_one_word_in_flight, in_accept |=> !s_tready, "second word taken while busy")
    `RSD_ASSERT(a_div_done_in_div, div_done |-> (state_reg == ST_SLOW_DIV || state_reg == ST_FAST_DIV), "divider result outside a division state")
    `RSD_ASSERT(a_clear_zeroes_avgs, (state_reg == ST_EMIT && mode_reg) |-> (slow_avg_reg == '0 && fast_avg_reg == '0), "clear word left averages set")
    `RSD_ASSERT(a_seen_saturates, seen_reg <= SEEN_W'(WARMUP_SAMPLES), "sample count above warm-up limit")

endmodule

// File: dv/tb_regime_shift_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Regime shift detector testbench
// Streams samples and clear words through the detector under random idling
// on both sides, predicts every result word from its own model of the two
// running averages and the regime state, and compares the words field by field.
// ----------------------------------------------------------------------------
module tb_regime_shift_detector;
    import rsd_pkg::*;

    localparam int          STALL_LIMIT = 2000;
    localparam logic [63:0] SAMPLE_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SAMPLE_MIN  = 64'h8000_0000_0000_0000;

    typedef struct packed {
        logic        escalated;
        logic        warmup_active;
        logic        event_raised;
        logic        event_held;
        logic [63:0] slow_average;
        logic [63:0] fast_average;
    } verdict_t;

    class regime_tracker;
        cfg_t        cfg;
        logic [63:0] slow_avg;
        logic [63:0] fast_avg;
        int          seen;
        logic        escalated;
        int          in_range_run;
        logic        event_held;
        verdict_t    due_verdicts[$];
        int          faults;

        function new();
            cfg.slow_window         = 16'd64;
            cfg.fast_window         = 16'd8;
            cfg.escalate_threshold  = 64'd1000;
            cfg.stable_threshold    = 64'd500;
            cfg.region_bound        = 1'b0;
            cfg.region_minimum      = '0;
            cfg.region_maximum      = '0;
            cfg.return_count_needed = 16'd4;
            faults = 0;
            clear_state();
        endfunction

        function void clear_state();
            slow_avg     = '0;
            fast_avg     = '0;
            seen         = 0;
            escalated    = 1'b0;
            in_range_run = 0;
            event_held   = 1'b0;
        endfunction

        function void set_register(reg_idx_t idx, logic [63:0] value);
            case (idx)
                REG_SLOW_WINDOW:     cfg.slow_window = value[15:0];
                REG_FAST_WINDOW:     cfg.fast_window = value[15:0];
                REG_ESCALATE_THRESH: cfg.escalate_threshold = value;
                REG_STABLE_THRESH:   cfg.stable_threshold = value;
                REG_REGION_BOUND:    cfg.region_bound = value[0];
                REG_REGION_MINIMUM:  cfg.region_minimum = value;
                REG_REGION_MAXIMUM:  cfg.region_maximum = value;
                REG_RETURN_COUNT:    cfg.return_count_needed = value[15:0];
                default: ;
            endcase
        endfunction

        // Moves an average toward the sample by the truncated distance over the window.
        function logic [63:0] move_toward(logic [63:0] avg, logic [63:0] value,
                                          logic [15:0] window);
            logic [63:0] divisor;
            logic [63:0] distance;
            logic [63:0] stride;
            logic        below;
            below    = $signed(value) < $signed(avg);
            divisor  = (window == 16'd0) ? 64'd1 : {48'd0, window};
            distance = below ? avg - value : value - avg;
            stride   = distance / divisor;
            return below ? avg - stride : avg + stride;
        endfunction

        function void track_sample(logic mode, logic [63:0] value);
            verdict_t    v;
            logic [63:0] spread;
            int          need;
            v.event_raised = 1'b0;
            if (mode) begin
                clear_state();
            end else begin
                if (seen == 0) begin
                    slow_avg = value;
                    fast_avg = value;
                end else begin
                    slow_avg = move_toward(slow_avg, value, cfg.slow_window);
                    fast_avg = move_toward(fast_avg, value, cfg.fast_window);
                end
                if (seen < WARMUP_SAMPLES) seen++;
                if (seen >= WARMUP_SAMPLES) begin
                    if (!cfg.region_bound) begin
                        spread = ($signed(fast_avg) < $signed(slow_avg)) ?
                                 slow_avg - fast_avg : fast_avg - slow_avg;
                        if (!escalated && spread > cfg.escalate_threshold) begin
                            escalated = 1'b1;
                        end else if (escalated && spread < cfg.stable_threshold) begin
                            escalated = 1'b0;
                        end
                    end else if ($signed(value) < $signed(cfg.region_minimum) ||
                                 $signed(cfg.region_maximum) < $signed(value)) begin
                        in_range_run = 0;
                        if (!escalated) begin
                            escalated      = 1'b1;
                            event_held     = 1'b1;
                            v.event_raised = 1'b1;
                        end
                    end else if (escalated) begin
                        need = (cfg.return_count_needed == 16'd0) ? 1 :
                               int'(cfg.return_count_needed);
                        in_range_run++;
                        if (in_range_run >= need) begin
                            escalated    = 1'b0;
                            in_range_run = 0;
                            event_held   = 1'b0;
                        end
                    end
                end
            end
            v.escalated     = escalated;
            v.warmup_active = (seen < WARMUP_SAMPLES);
            v.event_held    = event_held;
            v.slow_average  = slow_avg;
            v.fast_average  = fast_avg;
            due_verdicts.push_back(v);
        endfunction

        function void check_verdict(logic [OUT_TDATA_W-1:0] word);
            verdict_t got;
            verdict_t want;
            got.escalated     = word[0];
            got.warmup_active = word[1];
            got.event_raised  = word[2];
            got.event_held    = word[3];
            got.slow_average  = word[67:4];
            got.fast_average  = word[131:68];
            if (due_verdicts.size() == 0) begin
                faults++;
                if (faults <= 10) $display("unexpected result word %h", word);
                return;
            end
            want = due_verdicts.pop_front();
            if (got !== want) begin
                faults++;
                if (faults <= 10) begin
                    $display("mismatch: expected esc=%0b warm=%0b raised=%0b held=%0b slow=%0d fast=%0d",
                             want.escalated, want.warmup_active, want.event_raised,
                             want.event_held, $signed(want.slow_average),
                             $signed(want.fast_average));
                    $display("          actual   esc=%0b warm=%0b raised=%0b held=%0b slow=%0d fast=%0d",
                             got.escalated, got.warmup_active, got.event_raised,
                             got.event_held, $signed(got.slow_average),
                             $signed(got.fast_average));
                end
            end
        endfunction
    endclass

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [APB_ADDR_W-1:0]  paddr;
    logic [APB_DATA_W-1:0]  pwdata;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [DATA_W-1:0]      s_tdata;   // [63:0] sample
    logic                   s_tuser;   // [0] mode
    logic                   m_tvalid;
    logic                   m_tready;
    // [0] escalated, [1] warmup_active, [2] event_raised, [3] event_held,
    // [67:4] slow_average, [131:68] fast_average, [135:132] zero
    logic [OUT_TDATA_W-1:0] m_tdata;

    regime_tracker tracker;
    logic          calm = 1'b0;
    logic          bound_mode = 1'b0;
    logic [63:0]   region_lo = '0;
    logic [63:0]   region_hi = '0;
    logic [63:0]   level = '0;
    int            random_sent = 0;
    int            stale_cycles = 0;

    regime_shift_detector uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    always @(negedge aclk) begin
        m_tready <= calm || ($urandom_range(99) >= 13);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid === 1'b1 && m_tready) tracker.check_verdict(m_tdata);
    end

    // Ends the run if neither stream nor the register port moves for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready) || psel) begin
            stale_cycles <= 0;
        end else if (stale_cycles >= STALL_LIMIT) begin
            $display("tb_regime_shift_detector failed");
            $finish;
        end else begin
            stale_cycles <= stale_cycles + 1;
        end
    end

    function automatic logic [63:0] widen(int v);
        return {{32{v[31]}}, v};
    endfunction

    task automatic send_word(logic mode, logic [63:0] value);
        while (!calm && $urandom_range(99) < 13) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= value;
        do @(posedge aclk); while (s_tready !== 1'b1);
        tracker.track_sample(mode, value);
        @(negedge aclk);
    endtask

    task automatic write_register(reg_idx_t idx, logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        tracker.set_register(idx, value);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
    endtask

    // Stops offering words and waits until every predicted result has arrived.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (tracker.due_verdicts.size() != 0) @(negedge aclk);
    endtask

    task automatic configure(logic [15:0] slow_w, logic [15:0] fast_w,
                             logic [63:0] rise_at, logic [63:0] settle_at, logic bound,
                             logic [63:0] lo, logic [63:0] hi, logic [15:0] needed);
        drain();
        write_register(REG_SLOW_WINDOW, {48'd0, slow_w});
        write_register(REG_FAST_WINDOW, {48'd0, fast_w});
        write_register(REG_ESCALATE_THRESH, rise_at);
        write_register(REG_STABLE_THRESH, settle_at);
        write_register(REG_REGION_BOUND, {63'd0, bound});
        write_register(REG_REGION_MINIMUM, lo);
        write_register(REG_REGION_MAXIMUM, hi);
        write_register(REG_RETURN_COUNT, {48'd0, needed});
        bound_mode = bound;
        region_lo  = lo;
        region_hi  = hi;
        if (bound) level = ($signed(lo) >>> 1) + ($signed(hi) >>> 1);
    endtask

    // Mostly noisy samples around a level that shifts now and then, with
    // clears, raw random words, extremes and region edges mixed in.
    task automatic run_random(int count, int span);
        int          pick;
        int          jitter;
        int          hop;
        logic        mode;
        logic [63:0] value;
        for (int n = 0; n < count; n++) begin
            calm = (random_sent >= 350 && random_sent < 520);
            random_sent++;
            pick   = $urandom_range(199);
            jitter = int'($urandom_range(2 * span)) - span;
            value  = level + widen(jitter);
            mode   = (pick < 3);
            if (mode || pick < 23) begin
                value = {$urandom, $urandom};
            end else if (pick < 31) begin
                case ($urandom_range(3))
                    0: value = SAMPLE_MAX;
                    1: value = SAMPLE_MIN;
                    2: value = '0;
                    default: value = '1;
                endcase
            end else if (pick < 47) begin
                if (bound_mode) begin
                    case ($urandom_range(3))
                        0: value = region_lo;
                        1: value = region_hi;
                        2: value = region_lo - 64'd1;
                        default: value = region_hi + 64'd1;
                    endcase
                end else begin
                    hop = int'($urandom_range(1 << $urandom_range(6, 18)));
                    if ($urandom_range(1)) hop = -hop;
                    level = level + widen(hop);
                    value = level;
                end
            end else if (pick < 50 && !bound_mode) begin
                level = widen($urandom);
            end
            send_word(mode, value);
        end
    endtask

    initial begin
        aresetn  = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        s_tvalid = 1'b0;
        s_tuser  = 1'b0;
        s_tdata  = '0;
        m_tready = 1'b0;
        tracker  = new();
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part under reset settings: a clear that ignores its sample,
        // both extremes, then enough samples to finish warm-up.
        send_word(1'b1, '1);
        send_word(1'b0, SAMPLE_MAX);
        send_word(1'b0, SAMPLE_MIN);
        for (int k = 0; k < 14; k++) begin
            send_word(1'b0, widen((k % 2 == 0) ? k * 4099 : -k * 313));
        end

        // Switching to range checks keeps the state; a zero return count acts as one.
        drain();
        write_register(REG_REGION_BOUND, 64'd1);
        write_register(REG_REGION_MINIMUM, widen(-10));
        write_register(REG_REGION_MAXIMUM, 64'd10);
        write_register(REG_RETURN_COUNT, 64'd0);
        send_word(1'b0, 64'd0);
        send_word(1'b0, 64'd100);
        send_word(1'b0, 64'd0);

        // Zero windows take the whole distance in one move.
        drain();
        write_register(REG_SLOW_WINDOW, 64'd0);
        write_register(REG_FAST_WINDOW, 64'd0);
        send_word(1'b0, 64'd7);

        // A minimum above the maximum puts every sample out of range.
        drain();
        write_register(REG_REGION_MINIMUM, 64'd10);
        write_register(REG_REGION_MAXIMUM, widen(-10));
        send_word(1'b0, 64'd0);
        send_word(1'b1, 64'h5A5A_5A5A_5A5A_5A5A);

        configure(16'd64, 16'd8, 64'd1000, 64'd500, 1'b0, '0, '0, 16'd4);
        run_random(117, 300);
        configure(16'd65535, 16'd1, 64'd0, 64'd0, 1'b0, '0, '0, 16'd1);
        run_random(117, 300);
        configure(16'd1, 16'd65535, '1, '1, 1'b0, '0, '0, 16'd65535);
        run_random(117, 300);
        configure(16'd16, 16'd4, 64'd3000, 64'd200, 1'b1, widen(-1000), 64'd1000, 16'd3);
        run_random(117, 1500);
        configure(16'd0, 16'd0, 64'd1000, 64'd500, 1'b1, widen(-50), 64'd50, 16'd65535);
        run_random(117, 60);
        configure(16'd256, 16'd32, 64'd1, 64'd0, 1'b1, SAMPLE_MIN, SAMPLE_MAX, 16'd1);
        run_random(117, 300);
        configure(16'd2, 16'd2, 64'd0, '1, 1'b1, '0, '0, 16'd1);
        run_random(117, 2);
        configure(16'd100, 16'd10, 64'd500, 64'd400, 1'b1, 64'd500, widen(-500), 16'd0);
        run_random(117, 600);
        configure(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                  64'h4000_0000_0000_0000, 64'h1000_0000_0000_0000, 1'b0,
                  {$urandom, $urandom}, {$urandom, $urandom}, 16'($urandom_range(65535)));
        run_random(117, 300);

        drain();
        repeat (80) @(negedge aclk);
        if (tracker.faults == 0 && tracker.due_verdicts.size() == 0) begin
            $display("tb_regime_shift_detector passed");
        end else begin
            $display("tb_regime_shift_detector failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/rsd_pkg.sv
hw/rtl/rsd_regs.sv
hw/rtl/rsd_div.sv
hw/rtl/regime_shift_detector.sv
dv/tb_regime_shift_detector.sv
